// File: sv/sfp_pkg.sv
package sfp_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [31:0] MIN_BODY = 32'd20;
    localparam logic [3:0]  LEVEL_BYTES = 4'd12;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_SYMBOL = 2'd1,
        KIND_LEVEL  = 2'd2,
        KIND_STATUS = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TRUNCATED = 3'd1,
        ST_SHORT     = 3'd2,
        ST_MAGIC     = 3'd3,
        ST_CRC       = 3'd4,
        ST_LEVELS    = 3'd5,
        ST_OVERRUN   = 3'd6,
        ST_TRAILING  = 3'd7
    } status_t;

    localparam logic [0:0] REG_MAGIC = 1'b0;
    localparam logic [0:0] REG_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] sequence_res;
        logic [31:0] symbol_count;
        logic [63:0] symbol_code;
        logic        book_side;
        logic [7:0]  level_index;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [31:0] orders;
        logic [2:0]  status;
        logic        frame_last;
    } result_t;

    function automatic logic [31:0] crc_update(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: sv/sfp_front.sv
module sfp_front import sfp_pkg::*; #(
    parameter int SYMBOL_BYTES = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_end,
    input  logic [31:0]   magic_word,
    input  logic [7:0]    level_limit,
    output logic          res_valid,
    output result_t       res_data,
    input  logic          fifo_full
);

    typedef enum logic [2:0] {
        PH_LEN, PH_HDR, PH_SYM, PH_NB, PH_BID, PH_NA, PH_ASK, PH_SKIP
    } phase_t;

    phase_t      phase_reg;
    logic [32:0] pos_reg;
    logic [31:0] blen_reg;
    logic [31:0] crc_reg;
    logic [63:0] shift_reg;
    logic [3:0]  fcnt_reg;
    logic [31:0] syms_reg;
    logic [7:0]  lvl_left_reg;
    logic        side_reg;
    logic [7:0]  lvl_cnt_reg;
    logic [2:0]  err_reg;
    logic        fin_reg;
    logic [31:0] price_reg;
    logic [31:0] qty_reg;

    phase_t      phase_next;
    logic [31:0] blen_next, crc_next, syms_next, price_next, qty_next;
    logic [63:0] shift_next;
    logic [3:0]  fcnt_next;
    logic [7:0]  lvl_left_next, lvl_cnt_next;
    logic        side_next;
    logic [2:0]  err_next;
    result_t     r;
    logic        emit;

    logic        take;
    logic [32:0] o, c, p, room, need;
    logic [2:0]  st;

    assign in_ready = !fifo_full;
    assign take = in_valid && in_ready;

    always_comb begin
        phase_next = phase_reg; blen_next = blen_reg; crc_next = crc_reg;
        shift_next = shift_reg; fcnt_next = fcnt_reg; syms_next = syms_reg;
        lvl_left_next = lvl_left_reg; side_next = side_reg; lvl_cnt_next = lvl_cnt_reg;
        err_next = err_reg; price_next = price_reg; qty_next = qty_reg;
        r = '0; emit = 1'b0; st = ST_OK;
        o = pos_reg - 33'd4;
        c = {1'b0, blen_reg} - 33'd4;
        p = o + 33'd1;
        room = c - p;
        need = '0;
        if (!fin_reg) begin
            if (phase_reg == PH_LEN) begin
                blen_next = {blen_reg[23:0], in_byte};
                if (pos_reg == 33'd3) begin
                    if (blen_next < MIN_BODY) begin
                        err_next = ST_SHORT; phase_next = PH_SKIP;
                    end else begin
                        phase_next = PH_HDR;
                    end
                end
            end else if (err_reg == ST_SHORT) begin
            end else if (o >= c) begin
                qty_next = {qty_reg[23:0], in_byte};
            end else begin
                crc_next = crc_update(crc_reg, in_byte);
                if (o < 33'd4) begin
                    price_next = {price_reg[23:0], in_byte};
                    if (o == 33'd3 && price_next != magic_word) begin
                        if (err_reg == ST_OK) err_next = ST_MAGIC;
                        phase_next = PH_SKIP;
                    end
                end else if (err_reg != ST_OK) begin
                end else if (o < 33'd12) begin
                    shift_next = {shift_reg[55:0], in_byte};
                end else if (o < 33'd16) begin
                    price_next = {price_reg[23:0], in_byte};
                    if (o == 33'd15) begin
                        r.kind = KIND_HEADER; r.sequence_res = shift_reg;
                        r.symbol_count = price_next; emit = 1'b1;
                        syms_next = price_next;
                        if (syms_next == '0) begin
                            if (c != 33'd16) err_next = ST_TRAILING;
                            phase_next = PH_SKIP;
                        end else if (c - 33'd16 < 33'(SYMBOL_BYTES + 1)) begin
                            err_next = ST_OVERRUN; phase_next = PH_SKIP;
                        end else begin
                            phase_next = PH_SYM; fcnt_next = '0; shift_next = '0;
                        end
                    end
                end else begin
                    unique case (phase_reg)
                        PH_SYM: begin
                            shift_next = {shift_reg[55:0], in_byte};
                            fcnt_next = fcnt_reg + 4'd1;
                            if (fcnt_next >= 4'(SYMBOL_BYTES)) begin
                                r.kind = KIND_SYMBOL; r.symbol_code = shift_next;
                                emit = 1'b1; phase_next = PH_NB;
                            end
                        end
                        PH_NB, PH_NA: begin
                            need = 33'(in_byte) * 33'd12
                                 + ((phase_reg == PH_NB) ? 33'd1 : 33'd0);
                            if (in_byte > level_limit) begin
                                err_next = ST_LEVELS; phase_next = PH_SKIP;
                            end else if (room < need) begin
                                err_next = ST_OVERRUN; phase_next = PH_SKIP;
                            end else begin
                                lvl_left_next = in_byte; lvl_cnt_next = '0;
                                fcnt_next = '0; shift_next = '0;
                                if (phase_reg == PH_NB) begin
                                    side_next = 1'b0;
                                    phase_next = (in_byte != 8'd0) ? PH_BID : PH_NA;
                                end else begin
                                    side_next = 1'b1;
                                    if (in_byte != 8'd0) phase_next = PH_ASK;
                                    else begin
                                        syms_next = syms_reg - 32'd1;
                                        if (syms_next == '0) begin
                                            if (p != c) err_next = ST_TRAILING;
                                            phase_next = PH_SKIP;
                                        end else if (room < 33'(SYMBOL_BYTES + 1)) begin
                                            err_next = ST_OVERRUN; phase_next = PH_SKIP;
                                        end else begin
                                            phase_next = PH_SYM;
                                        end
                                    end
                                end
                            end
                        end
                        PH_BID, PH_ASK: begin
                            shift_next = {shift_reg[55:0], in_byte};
                            fcnt_next = fcnt_reg + 4'd1;
                            if (fcnt_next == 4'd4) price_next = shift_next[31:0];
                            else if (fcnt_next == 4'd8) qty_next = shift_next[31:0];
                            else if (fcnt_next >= LEVEL_BYTES) begin
                                r.kind = KIND_LEVEL; r.book_side = side_reg;
                                r.level_index = lvl_cnt_reg; r.price = price_reg;
                                r.quantity = qty_reg; r.orders = shift_next[31:0];
                                emit = 1'b1;
                                fcnt_next = '0; shift_next = '0;
                                lvl_cnt_next = lvl_cnt_reg + 8'd1;
                                lvl_left_next = lvl_left_reg - 8'd1;
                                if (lvl_left_next == '0) begin
                                    if (phase_reg == PH_BID) phase_next = PH_NA;
                                    else begin
                                        syms_next = syms_reg - 32'd1;
                                        if (syms_next == '0) begin
                                            if (p != c) err_next = ST_TRAILING;
                                            phase_next = PH_SKIP;
                                        end else if (room < 33'(SYMBOL_BYTES + 1)) begin
                                            err_next = ST_OVERRUN; phase_next = PH_SKIP;
                                        end else begin
                                            phase_next = PH_SYM;
                                        end
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            if (pos_reg + 33'd1 == 33'd4 + {1'b0, blen_next}) begin
                st = err_next;
                if (st != ST_SHORT && st != ST_MAGIC && ~crc_next != qty_next) st = ST_CRC;
                r = '0; r.kind = KIND_STATUS; r.status = st; r.frame_last = 1'b1;
                emit = 1'b1;
            end
        end
        if (in_end && !(fin_reg || emit && r.kind == KIND_STATUS && r.frame_last)) begin
            r = '0; r.kind = KIND_STATUS; r.status = ST_TRUNCATED; r.frame_last = 1'b1;
            emit = 1'b1;
        end
    end

    assign res_valid = take && emit;
    assign res_data  = r;

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && in_end)) begin
            phase_reg <= PH_LEN; pos_reg <= '0; blen_reg <= '0; crc_reg <= CRC_INIT;
            shift_reg <= '0; fcnt_reg <= '0; syms_reg <= '0; lvl_left_reg <= '0;
            side_reg <= 1'b0; lvl_cnt_reg <= '0; err_reg <= ST_OK; fin_reg <= 1'b0;
            price_reg <= '0; qty_reg <= '0;
        end else if (take && !fin_reg) begin
            phase_reg <= phase_next; pos_reg <= pos_reg + 33'd1; blen_reg <= blen_next;
            crc_reg <= crc_next; shift_reg <= shift_next; fcnt_reg <= fcnt_next;
            syms_reg <= syms_next; lvl_left_reg <= lvl_left_next; side_reg <= side_next;
            lvl_cnt_reg <= lvl_cnt_next; err_reg <= err_next;
            price_reg <= price_next; qty_reg <= qty_next;
            if (emit && r.kind == KIND_STATUS) fin_reg <= 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_no_emit_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_full |-> !res_valid) else $error("result while queue full");
    a_finish_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_data.kind == KIND_STATUS && !in_end) |=> fin_reg)
        else $error("frame not marked finished");
    a_no_item_after_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_reg |-> !res_valid) else $error("result after the frame had finished");
`endif

endmodule

// File: sv/sfp_queue.sv
module sfp_queue import sfp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    wr_valid,
    input  result_t wr_data,
    output logic    full,
    output logic    rd_valid,
    output result_t rd_data,
    input  logic    rd_ready
);

    result_t    mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       push, pop;

    assign full     = (cnt_reg == 3'd4);
    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && !full;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop)  rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, push} - {2'd0, pop};
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'd4) else $error("queue count out of range");
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 3'd1) else $error("count slip");
    a_pop_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> cnt_reg == $past(cnt_reg) - 3'd1) else $error("count slip");
`endif

endmodule

// File: sv/snapshot_frame_parser.sv
// Channel  | Direction | Ports                      | Word
// s_       | in        | s_valid s_ready s_*        | one buffer byte
// m_       | out       | m_valid m_ready m_*        | one parsed item or status
// cfg      | in        | APB psel .. pready         | magic_word, level_limit
// One byte is parsed per cycle; the front parser works the whole byte combinationally.
// Results pass through a four-word queue, so the input stalls only when it is full.
// Reset is synchronous on aresetn low and clears parser and queue state.
// buffer_end returns the parser, not the registers, to its reset state.
module snapshot_frame_parser import sfp_pkg::*; #(
    parameter int SYMBOL_BYTES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_buffer_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [63:0] m_sequence_res,
    output logic [31:0] m_symbol_count,
    output logic [63:0] m_symbol_code,
    output logic        m_book_side,
    output logic [7:0]  m_level_index,
    output logic [31:0] m_price,
    output logic [31:0] m_quantity,
    output logic [31:0] m_order_count,
    output logic [2:0]  m_status,
    output logic        m_frame_last
);

    logic [31:0] magic_reg;
    logic [7:0]  limit_reg;
    logic        fe_valid, q_full;
    result_t     fe_data, q_data;

    assign pready = 1'b1;

    // Register writes land on the access cycle of the APB transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg <= '0;
            limit_reg <= 8'd16;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_MAGIC) magic_reg <= pwdata;
            else limit_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_MAGIC) ? magic_reg : {24'd0, limit_reg};

    sfp_front #(.SYMBOL_BYTES(SYMBOL_BYTES)) u_front (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready),
        .in_byte(s_data_byte), .in_end(s_buffer_end),
        .magic_word(magic_reg), .level_limit(limit_reg),
        .res_valid(fe_valid), .res_data(fe_data), .fifo_full(q_full)
    );

    sfp_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(fe_valid), .wr_data(fe_data), .full(q_full),
        .rd_valid(m_valid), .rd_data(q_data), .rd_ready(m_ready)
    );

    assign m_kind = q_data.kind;
    assign m_sequence_res = q_data.sequence_res;
    assign m_symbol_count = q_data.symbol_count;
    assign m_symbol_code = q_data.symbol_code;
    assign m_book_side = q_data.book_side;
    assign m_level_index = q_data.level_index;
    assign m_price = q_data.price;
    assign m_quantity = q_data.quantity;
    assign m_order_count = q_data.orders;
    assign m_status = q_data.status;
    assign m_frame_last = q_data.frame_last;

endmodule
